// ===== rtl/bta_pkg.sv =====
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, codes and defaults for the bakery ticket arbiter.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int REQUESTERS_DEF   = 8;
  localparam int TICKET_WIDTH_DEF = 16;

  localparam int ID_W     = 3;
  localparam int GIVEN_W  = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 4;

  localparam logic [CFG_W-1:0] ACTIVE_RST = 4'd8;

  localparam logic KIND_REQ = 1'b0;
  localparam logic KIND_REL = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_HELD = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] requester;
  } in_item_t;

  typedef struct packed {
    logic                grant_valid;
    logic [ID_W-1:0]     grant_id;
    logic [GIVEN_W-1:0]  ticket_given;
    logic [STATUS_W-1:0] status;
  } out_item_t;

endpackage

// ===== rtl/bta_ticket_mem.sv =====
// ----------------------------------------------------------------------------
// bta_ticket_mem
// Ticket store: one write port, one registered read port. Per-entry valid
// bits cleared by reset; an entry that is not valid reads as zero.
// ----------------------------------------------------------------------------
module bta_ticket_mem
  import bta_pkg::*;
#(
  parameter int REQUESTERS   = REQUESTERS_DEF,
  parameter int TICKET_WIDTH = TICKET_WIDTH_DEF,
  localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic                    wr_clr,
  input  logic [IDX_W-1:0]        wr_addr,
  input  logic [TICKET_WIDTH-1:0] wr_data,
  input  logic [IDX_W-1:0]        rd_addr,
  output logic [TICKET_WIDTH-1:0] rd_data
);

  logic [TICKET_WIDTH-1:0] mem [REQUESTERS];
  logic [REQUESTERS-1:0]   vld_r;
  logic [TICKET_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= !wr_clr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !wr_clr) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/bta_scan_unit.sv =====
// ----------------------------------------------------------------------------
// bta_scan_unit
// Compare/accumulate unit: with en high, folds one ticket per cycle into the
// running maximum, smallest nonzero ticket with its id, and issuer's ticket.
// ----------------------------------------------------------------------------
module bta_scan_unit
  import bta_pkg::*;
#(
  parameter int REQUESTERS   = REQUESTERS_DEF,
  parameter int TICKET_WIDTH = TICKET_WIDTH_DEF,
  localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1
) (
  input  logic                    clk,
  input  logic                    clr,
  input  logic                    en,
  input  logic [TICKET_WIDTH-1:0] tkt,
  input  logic [IDX_W-1:0]        tkt_id,
  input  logic [ID_W-1:0]         who,
  input  logic                    excl_who,
  output logic [TICKET_WIDTH-1:0] top,
  output logic [IDX_W-1:0]        best_id,
  output logic                    best_vld,
  output logic [TICKET_WIDTH-1:0] own
);

  logic [TICKET_WIDTH-1:0] top_r, best_r, own_r;
  logic [IDX_W-1:0]        best_id_r;
  logic                    best_vld_r;
  logic                    is_who;
  logic [TICKET_WIDTH-1:0] cand;

  assign is_who = (tkt_id == IDX_W'(who));
  // a released entry is left out of the minimum
  assign cand   = (excl_who && is_who) ? '0 : tkt;

  always_ff @(posedge clk) begin
    if (clr) begin
      top_r      <= '0;
      best_r     <= '0;
      own_r      <= '0;
      best_id_r  <= '0;
      best_vld_r <= 1'b0;
    end else if (en) begin
      if (tkt > top_r) begin
        top_r <= tkt;
      end
      if (is_who) begin
        own_r <= tkt;
      end
      if (cand != '0 && (!best_vld_r || cand < best_r)) begin
        best_r     <= cand;
        best_id_r  <= tkt_id;
        best_vld_r <= 1'b1;
      end
    end
  end

  assign top      = top_r;
  assign best_id  = best_id_r;
  assign best_vld = best_vld_r;
  assign own      = own_r;

endmodule

// ===== rtl/bakery_ticket_arbiter.sv =====
// ----------------------------------------------------------------------------
// bakery_ticket_arbiter
// Sequence: after input accept the scan reads and compares one ticket per cycle
//   over n = active count entries, then S_DRAIN and S_DONE.
// in_ready only while idle, so no new transaction until the result is stored.
// Reset: synchronous, active low; all tickets cleared via valid bits,
//   active count back to 8.
// ----------------------------------------------------------------------------
module bakery_ticket_arbiter
  import bta_pkg::*;
#(
  parameter int REQUESTERS   = REQUESTERS_DEF,
  parameter int TICKET_WIDTH = TICKET_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item
);

  localparam int IDX_W = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
  localparam int CNT_W = $clog2(REQUESTERS + 1);
  localparam int CMP_W = (CNT_W > ID_W) ? CNT_W : ID_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] cfg_r;
  logic [CNT_W-1:0] n_act;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             rdv_r;
  logic [IDX_W-1:0] rid_r;
  logic             kind_r;
  logic [ID_W-1:0]  who_r;
  logic             who_act;
  logic             out_valid_r;
  out_item_t        out_item_r, res;
  logic             fire;

  logic                    wr_en, wr_clr;
  logic [TICKET_WIDTH-1:0] wr_data, rd_data;
  logic [TICKET_WIDTH-1:0] top, own;
  logic [IDX_W-1:0]        best_id;
  logic                    best_vld;

  // active count clamped to 1..REQUESTERS
  always_comb begin
    if (cfg_r == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(cfg_r) > REQUESTERS) begin
      n_act = CNT_W'(REQUESTERS);
    end else begin
      n_act = CNT_W'(cfg_r);
    end
  end

  assign who_act  = (CMP_W'(who_r) < CMP_W'(n_act));
  assign in_ready = (state_r == S_IDLE);
  assign idx_nxt  = idx_r + CNT_W'(1);
  assign fire     = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= ACTIVE_RST;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_SCAN;
      S_SCAN:  if (idx_nxt == n_act) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_DONE;
      S_DONE:  if (fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      rdv_r   <= (state_r == S_SCAN);
      if (state_r == S_IDLE) begin
        idx_r <= '0;
      end else if (state_r == S_SCAN) begin
        idx_r <= idx_nxt;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      kind_r <= in_item.kind;
      who_r  <= in_item.requester;
    end
    rid_r <= idx_r[IDX_W-1:0];
    if (fire) begin
      out_item_r <= res;
    end
  end

  // decision after the scan; the new ticket exceeds every active entry's, so it
  // only takes the grant when nobody else holds a ticket
  always_comb begin
    res.grant_valid  = best_vld;
    res.grant_id     = ID_W'(best_id);
    res.ticket_given = '0;
    res.status       = ST_OK;
    wr_en            = 1'b0;
    wr_clr           = 1'b0;
    wr_data          = top + TICKET_WIDTH'(1);
    if (who_act) begin
      if (kind_r == KIND_REL) begin
        wr_en  = fire;
        wr_clr = 1'b1;
      end else if (own != '0) begin
        res.status = ST_HELD;
      end else if (top == '1) begin
        res.status = ST_OVF;
      end else begin
        wr_en            = fire;
        res.ticket_given = GIVEN_W'(wr_data);
        if (!best_vld) begin
          res.grant_valid = 1'b1;
          res.grant_id    = who_r;
        end
      end
    end
  end

  bta_ticket_mem #(
    .REQUESTERS   (REQUESTERS),
    .TICKET_WIDTH (TICKET_WIDTH)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (wr_en),
    .wr_clr  (wr_clr),
    .wr_addr (IDX_W'(who_r)),
    .wr_data (wr_data),
    .rd_addr (idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  bta_scan_unit #(
    .REQUESTERS   (REQUESTERS),
    .TICKET_WIDTH (TICKET_WIDTH)
  ) u_scan (
    .clk      (clk),
    .clr      (state_r == S_IDLE),
    .en       (rdv_r),
    .tkt      (rd_data),
    .tkt_id   (rid_r),
    .who      (who_r),
    .excl_who (who_act && kind_r == KIND_REL),
    .top      (top),
    .best_id  (best_id),
    .best_vld (best_vld),
    .own      (own)
  );

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ===== tb/tb_bakery_ticket_arbiter.sv =====
// ----------------------------------------------------------------------------
// tb_bakery_ticket_arbiter
// Self-checking bench for the bakery ticket arbiter. A queue-fed driver sends
// request/release transactions; a shadow ticket table predicts grant, ticket
// and status for each one. Runs directed corner cases and random phases over
// several active counts.
// ----------------------------------------------------------------------------
module tb_bakery_ticket_arbiter;
  import bta_pkg::*;

  localparam int NREQ        = REQUESTERS_DEF;
  localparam int TW          = TICKET_WIDTH_DEF;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 12;

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid  = 1'b0;
  logic             in_ready;
  in_item_t         in_item   = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_item_t        out_item;

  bakery_ticket_arbiter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  // shadow of the arbiter state
  logic [TW-1:0]    tickets_held [NREQ];
  logic [CFG_W-1:0] active_cfg = ACTIVE_RST;
  // stimulus-side view of who holds a ticket
  bit               holds [NREQ];

  in_item_t  items_waiting [$];
  out_item_t grants_due [$];
  out_item_t seen_grant;
  int        in_wait    = 0;
  int        out_wait   = 0;
  int        err_count  = 0;
  int        idle_count = 0;
  bit        quiet      = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int active_span(input logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > NREQ) return NREQ;
    return int'(v);
  endfunction

  function automatic int pick_gap();
    return quiet ? 0 : int'($urandom_range(0, 9));
  endfunction

  // applies one transaction to the shadow table, returns the expected result
  function automatic out_item_t grant_after(input in_item_t it);
    int            n;
    int            who;
    logic [TW-1:0] top;
    logic [TW-1:0] best;
    out_item_t     r;
    n    = active_span(active_cfg);
    who  = int'(it.requester);
    r    = '0;
    top  = '0;
    best = '0;
    if (who < n) begin
      if (it.kind == KIND_REL) begin
        tickets_held[who] = '0;
      end else if (tickets_held[who] != 0) begin
        r.status = ST_HELD;
      end else begin
        for (int i = 0; i < n; i++)
          if (tickets_held[i] > top) top = tickets_held[i];
        if (top == {TW{1'b1}}) begin
          r.status = ST_OVF;
        end else begin
          tickets_held[who] = top + 1'b1;
          r.ticket_given    = GIVEN_W'(top + 1'b1);
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (tickets_held[i] != 0 && (!r.grant_valid || tickets_held[i] < best)) begin
        r.grant_valid = 1'b1;
        r.grant_id    = ID_W'(i);
        best          = tickets_held[i];
      end
    end
    return r;
  endfunction

  // driver: one NBA per signal per edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_wait = 0;
      for (int i = 0; i < NREQ; i++) tickets_held[i] = '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) grants_due.push_back(grant_after(in_item));
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (items_waiting.size() != 0) begin
        in_item  <= items_waiting.pop_front();
        in_valid <= 1'b1;
        in_wait = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: stall counts only while a result is offered
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          err_count++;
          $display("%0t: unexpected transaction, expected none, got %p",
                   $time, out_item);
        end else begin
          seen_grant = grants_due.pop_front();
          if (out_item !== seen_grant) begin
            err_count++;
            $display({"%0t: expected valid=%0d id=%0d ticket=%0d status=%0d,",
                      " got valid=%0d id=%0d ticket=%0d status=%0d"},
                     $time, seen_grant.grant_valid, seen_grant.grant_id,
                     seen_grant.ticket_given, seen_grant.status,
                     out_item.grant_valid, out_item.grant_id,
                     out_item.ticket_given, out_item.status);
          end
        end
        out_wait = pick_gap();
      end else if (out_valid && out_wait > 0) begin
        out_wait--;
      end
      out_ready <= (out_wait == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_count <= 0;
    else idle_count <= idle_count + 1;
    if (idle_count >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(input logic k, input int who);
    in_item_t it;
    it.kind      = k;
    it.requester = ID_W'(who);
    if (who < active_span(active_cfg)) holds[who] = (k == KIND_REQ);
    items_waiting.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (items_waiting.size() != 0 || in_valid || grants_due.size() != 0);
  endtask

  task automatic set_active(input logic [CFG_W-1:0] v);
    wait_drained();
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    active_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed: holders release, others request; some noise
  task automatic random_traffic(input int count);
    int   n;
    int   who;
    bit   tidy;
    logic k;
    n = active_span(active_cfg);
    repeat (count) begin
      who  = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, NREQ - 1))
                                         : int'($urandom_range(0, n - 1));
      tidy = ($urandom_range(0, 99) < 85);
      if (holds[who]) k = tidy ? KIND_REL : KIND_REQ;
      else            k = tidy ? KIND_REQ : KIND_REL;
      send(k, who);
    end
  endtask

  initial begin
    logic [CFG_W-1:0] phase_cfg [10] = '{4'd8, 4'd3, 4'd15, 4'd1, 4'd0,
                                          4'd5, 4'd2, 4'd9, 4'd6, 4'd8};
    for (int i = 0; i < NREQ; i++) holds[i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: release with nothing held, re-request, grant handoff
    send(KIND_REL, 0);
    send(KIND_REQ, 0);
    send(KIND_REQ, 0);
    send(KIND_REQ, 7);
    send(KIND_REQ, 3);
    send(KIND_REL, 0);
    send(KIND_REL, 7);
    send(KIND_REL, 3);
    send(KIND_REQ, 6);
    // r6 goes inactive but keeps its ticket; r1 then draws the same value
    set_active(4'd2);
    send(KIND_REQ, 1);
    send(KIND_REQ, 0);
    send(KIND_REQ, 6);
    send(KIND_REL, 7);
    // back to full width: equal tickets, lower id wins
    set_active(4'd8);
    send(KIND_REL, 3);
    send(KIND_REL, 1);
    send(KIND_REL, 6);
    send(KIND_REL, 0);
    // zero acts as one, values above the max clamp
    set_active(4'd0);
    send(KIND_REQ, 7);
    send(KIND_REQ, 0);
    send(KIND_REQ, 0);
    send(KIND_REL, 0);
    set_active(4'd15);
    send(KIND_REQ, 7);
    send(KIND_REL, 7);

    for (int p = 0; p < 10; p++) begin
      wait_drained();
      quiet = (p == 2 || p == 6);
      set_active(phase_cfg[p]);
      random_traffic(110);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (grants_due.size() != 0) begin
      err_count++;
      $display("%0t: %0d expected transactions never arrived", $time, grants_due.size());
    end
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
